FILE: hdl/rmsn_pkg.sv
// Types and constants shared by the RMS row normalization block.
package rmsn_pkg;

    // Input beat: one row element and the gain of its column
    typedef struct packed {
        logic signed [15:0] element_value;  // Q8.8
        logic signed [15:0] gamma_value;    // Q4.12
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic signed [15:0] normalized_value;  // Q8.8, saturated
        logic               last_of_row;
    } t_out_item;

    // Configuration register indexes
    localparam logic CFG_ROW_LENGTH = 1'b0;
    localparam logic CFG_EPSILON    = 1'b1;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned SUM_W      = 37;   // running sum of squares
    localparam int unsigned ACC_W      = 65;   // shared remainder / radicand
    localparam int unsigned QUO_W      = 64;   // quotient shift register
    localparam int unsigned SCALE_W    = 33;   // reciprocal sqrt, up to 2^32
    localparam int unsigned M1_W       = 16 + SCALE_W;
    localparam int unsigned PROD_W     = M1_W + 16;
    localparam int unsigned PROD_SHIFT = 36;

    localparam logic [6:0]  ROW_LENGTH_RST = 7'd64;
    localparam logic [15:0] EPSILON_RST    = 16'd1;

endpackage

FILE: hdl/rms_normalization_row.sv
// RMS normalization of one row: load, shared divide/sqrt sequencer, scaled output.
//
// Elements load one per cycle while busy is low; each is stored with its gain and its
// square added to a running sum. The beat that completes a row raises busy. The block
// then runs one shared 65-bit subtract/compare unit for the mean square divide, the
// 2^64/v divide (skipped when v <= 1) and the integer square root, then takes each
// element through S_RD, S_MUL1, S_MUL2 and S_SAT (memory read, two multiplies,
// saturation); busy falls as the last result of the row is shown. Each result is
// shown for exactly one cycle under o_result_valid and
// cannot be held off; the final one carries last_of_row.
module rms_normalization_row
    import rmsn_pkg::*;
#(
    parameter int unsigned MAX_ROW = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_in_item,
    output logic                  o_result_valid,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
    localparam int unsigned CW = $clog2(MAX_ROW + 1);
    localparam logic [7:0]  MAX_ROW_L = 8'(MAX_ROW);

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_MEAN  = 8'b0000_0010,
        S_RECIP = 8'b0000_0100,
        S_SQRT  = 8'b0000_1000,
        S_RD    = 8'b0001_0000,
        S_MUL1  = 8'b0010_0000,
        S_MUL2  = 8'b0100_0000,
        S_SAT   = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [6:0]          r_row_length;
    logic [15:0]         r_epsilon;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_n, n_n;
    logic [AW-1:0]       r_k, n_k;
    logic [6:0]          r_step, n_step;
    logic [ACC_W-1:0]    r_a, n_a;
    logic [QUO_W-1:0]    r_q, n_q;
    logic [31:0]         r_d, n_d;
    logic [QUO_W-1:0]    r_res, n_res;
    logic [QUO_W-1:0]    r_bit, n_bit;
    logic [31:0]         r_mem [MAX_ROW];
    logic [31:0]         r_rd;
    logic [M1_W-1:0]     r_m1;
    logic [15:0]         r_ag;
    logic                r_neg;
    logic [PROD_W-1:0]   r_prod;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                accept;
    logic [7:0]          len_eff;
    logic [7:0]          cnt_inc;
    logic [31:0]         sq;
    logic [SUM_W-1:0]    sum_new;
    logic [ACC_W-1:0]    sub_a, sub_b;
    logic [ACC_W:0]      diff;
    logic                ge;
    logic [QUO_W-1:0]    q_shift;
    logic [31:0]         v_val;
    logic signed [15:0]  e_val, g_val;
    logic [15:0]         ae;
    logic [28:0]         mag;
    logic                last_k;

    assign accept = start && !busy;
    assign busy   = (r_state != S_LOAD);

    // Effective row length: zero counts as one, clipped to the store depth
    always_comb begin
        priority if (r_row_length == 7'd0) begin
            len_eff = 8'd1;
        end else if ({1'b0, r_row_length} > MAX_ROW_L) begin
            len_eff = MAX_ROW_L;
        end else begin
            len_eff = {1'b0, r_row_length};
        end
    end

    assign cnt_inc = 8'(r_count) + 8'd1;
    assign sq      = $unsigned(32'(i_in_item.element_value) * 32'(i_in_item.element_value));
    assign sum_new = r_sum + SUM_W'(sq);

    // Shared subtract/compare: divide steps or square-root steps
    always_comb begin
        if (r_state == S_SQRT) begin
            sub_a = r_a;
            sub_b = ACC_W'(r_res | r_bit);
        end else begin
            sub_a = {r_a[ACC_W-2:0], r_q[QUO_W-1]};
            sub_b = ACC_W'(r_d);
        end
    end

    assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge      = !diff[ACC_W];
    assign q_shift = {r_q[QUO_W-2:0], ge};
    assign v_val   = q_shift[31:0] + {16'd0, r_epsilon};

    // Output datapath operands
    assign e_val  = r_rd[15:0];
    assign g_val  = r_rd[31:16];
    assign ae     = e_val[15] ? 16'(-e_val) : e_val;
    assign mag    = r_prod[PROD_W-1:PROD_SHIFT];
    assign last_k = (CW'(r_k) + CW'(1) == r_n);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_count = r_count;
        n_n     = r_n;
        n_k     = r_k;
        n_step  = r_step;
        n_a     = r_a;
        n_q     = r_q;
        n_d     = r_d;
        n_res   = r_res;
        n_bit   = r_bit;
        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (cnt_inc >= len_eff) begin
                        n_n     = CW'(cnt_inc);
                        n_count = '0;
                        n_sum   = '0;
                        n_q     = {sum_new, (QUO_W-SUM_W)'(0)};
                        n_a     = '0;
                        n_d     = 32'(cnt_inc);
                        n_step  = 7'(SUM_W - 1);
                        n_state = S_MEAN;
                    end else begin
                        n_count = CW'(cnt_inc);
                        n_sum   = sum_new;
                    end
                end
            end
            S_MEAN, S_RECIP: begin
                n_a    = ge ? diff[ACC_W-1:0] : sub_a;
                n_q    = q_shift;
                n_step = r_step - 7'd1;
                if (r_step == 7'd0) begin
                    if (r_state == S_MEAN) begin
                        if (v_val <= 32'd1) begin
                            n_res   = QUO_W'(1) << 32;
                            n_k     = '0;
                            n_state = S_RD;
                        end else begin
                            n_a     = ACC_W'(1);
                            n_q     = '0;
                            n_d     = v_val;
                            n_step  = 7'(QUO_W - 1);
                            n_state = S_RECIP;
                        end
                    end else begin
                        n_a     = ACC_W'(q_shift);
                        n_res   = '0;
                        n_bit   = QUO_W'(1) << 62;
                        n_step  = 7'd31;
                        n_state = S_SQRT;
                    end
                end
            end
            S_SQRT: begin
                if (ge) begin
                    n_a   = diff[ACC_W-1:0];
                    n_res = (r_res >> 1) | r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit  = r_bit >> 2;
                n_step = r_step - 7'd1;
                if (r_step == 7'd0) begin
                    n_k     = '0;
                    n_state = S_RD;
                end
            end
            S_RD:   n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SAT;
            S_SAT: begin
                if (last_k) begin
                    n_state = S_LOAD;
                end else begin
                    n_k     = r_k + AW'(1);
                    n_state = S_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_sum        <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_row_length <= ROW_LENGTH_RST;
            r_epsilon    <= EPSILON_RST;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_out_valid <= (r_state == S_SAT);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROW_LENGTH: r_row_length <= i_cfg_data[6:0];
                    CFG_EPSILON:    r_epsilon    <= i_cfg_data;
                    default:        r_epsilon    <= r_epsilon;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_k    <= n_k;
        r_step <= n_step;
        r_a    <= n_a;
        r_q    <= n_q;
        r_d    <= n_d;
        r_res  <= n_res;
        r_bit  <= n_bit;
        if (r_state == S_MUL1) begin
            r_m1  <= ae * r_res[SCALE_W-1:0];
            r_ag  <= g_val[15] ? 16'(-g_val) : g_val;
            r_neg <= e_val[15] ^ g_val[15];
        end
        if (r_state == S_MUL2) begin
            r_prod <= r_m1 * r_ag;
        end
        if (r_state == S_SAT) begin
            r_out.last_of_row <= last_k;
            if (r_neg) begin
                r_out.normalized_value <= (mag >= 29'd32768) ? 16'sh8000
                                                              : 16'(-mag[15:0]);
            end else begin
                r_out.normalized_value <= (mag >= 29'd32767) ? 16'sh7fff : mag[15:0];
            end
        end
    end

    // Element and gain store
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_count[AW-1:0]] <= {i_in_item.gamma_value, i_in_item.element_value};
        end
        r_rd <= r_mem[r_k];
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

`ifndef NO_ASSERTIONS
    // A result beat only follows the saturation step
    a_valid_after_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == S_SAT))
        else $error("result beat without saturation step");

    // The last beat of a row returns the block to loading
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_of_row) |-> (r_state == S_LOAD))
        else $error("row end beat while still busy");

    // While loading, the fill count stays inside the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (32'(r_count) < MAX_ROW))
        else $error("element count beyond store depth");
`endif

endmodule

FILE: tb/sv/rms_normalization_row_test.sv
// Self-checking testbench for the RMS row normalization block.
module rms_normalization_row_test;
    import rmsn_pkg::*;

    // Result checker: holds the expected normalized outputs of each finished row
    class row_scoreboard;
        t_out_item   norm_queue[$];
        logic [15:0] elem_mem[64];
        logic [15:0] gain_mem[64];
        logic [36:0] sq_sum;
        int unsigned elem_cnt;
        int unsigned row_len;
        int unsigned eps;
        int unsigned mismatches;

        function void clear();
            sq_sum = '0;
            elem_cnt = 0;
            row_len = 64;
            eps = 1;
            mismatches = 0;
            norm_queue.delete();
        endfunction

        function void set_reg(logic idx, logic [15:0] data);
            if (idx == CFG_ROW_LENGTH) row_len = data[6:0];
            else eps = data;
        endfunction

        // Largest s with s*s*v <= 2^64
        function logic [63:0] inv_sqrt(logic [63:0] v);
            logic [127:0] lo, hi, mid, lim;
            if (v <= 1) return 64'd1 << 32;
            lim = 128'd1 << 64;
            lo = 0;
            hi = (128'd1 << 32) + 1;
            while (hi - lo > 1) begin
                mid = (lo + hi) >> 1;
                if (mid * mid * v <= lim) lo = mid;
                else hi = mid;
            end
            return lo[63:0];
        endfunction

        // Note one accepted input beat and predict the row if it ends here
        function void note_beat(t_in_item it);
            int unsigned len, idx, n;
            logic [63:0] mean, s, mag;
            logic [15:0] ae, ag;
            logic [127:0] prod;
            t_out_item r;
            len = row_len;
            if (len == 0) len = 1;
            if (len > 64) len = 64;
            idx = elem_cnt % 64;
            elem_mem[idx] = it.element_value;
            gain_mem[idx] = it.gamma_value;
            ae = it.element_value[15] ? -it.element_value : it.element_value;
            sq_sum = sq_sum + 37'(ae) * 37'(ae);
            elem_cnt = idx + 1;
            if (elem_cnt < len) return;
            n = elem_cnt;
            mean = 64'(sq_sum) / n;
            s = inv_sqrt(mean + eps);
            for (int k = 0; k < n; k++) begin
                ae = elem_mem[k][15] ? -elem_mem[k] : elem_mem[k];
                ag = gain_mem[k][15] ? -gain_mem[k] : gain_mem[k];
                prod = 128'(ae) * 128'(s) * 128'(ag);
                mag = 64'(prod >> 36);
                if (elem_mem[k][15] != gain_mem[k][15])
                    r.normalized_value = mag >= 32768 ? -16'sd32768 : -16'(mag);
                else
                    r.normalized_value = mag >= 32767 ? 16'sd32767 : 16'(mag);
                r.last_of_row = (k + 1 == n);
                norm_queue.push_back(r);
            end
            sq_sum = '0;
            elem_cnt = 0;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (norm_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d", got.normalized_value);
                return;
            end
            want = norm_queue.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d/%0b got %0d/%0b", want.normalized_value,
                             want.last_of_row, got.normalized_value, got.last_of_row);
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    t_in_item    in_item;
    logic        result_valid;
    t_out_item   result;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    row_scoreboard sb;
    int idle_cycles;

    rms_normalization_row i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy),
        .i_in_item(in_item), .o_result_valid(result_valid), .o_result(result),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // Clock
    always begin
        clk = 1'b1; #6;
        clk = 1'b0; #6;
    end

    // Result monitor and stall watchdog
    always @(posedge clk) begin
        if (rst_n && result_valid) sb.check_result(result);
        if (!rst_n || result_valid || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Write one register while the block is idle
    task automatic write_reg(logic idx, logic [15:0] data);
        start <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
        cfg_we <= 1'b0;
    endtask

    // Present one beat after a random gap (none when no_gap is set) and wait for acceptance;
    // start stays high so a following beat can go out back to back
    task automatic send_beat(logic [15:0] e, logic [15:0] g, bit no_gap = 0);
        t_in_item it;
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.element_value = e;
        it.gamma_value = g;
        start <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_beat(it);
    endtask

    // Wait for every expected result, then let the block settle
    task automatic drain();
        start <= 1'b0;
        while (sb.norm_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random element drawn with a bias toward extremes
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int lens[6] = '{1, 64, 3, 0, 100, 7};
        int eps_vals[4] = '{0, 65535, 1, 300};
        int sent, len, rl;
        sb = new();
        sb.clear();
        idle_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_ROW_LENGTH;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-element rows with extremes, zero square sum with zero epsilon
        write_reg(CFG_ROW_LENGTH, 16'd1);
        write_reg(CFG_EPSILON, 16'd0);
        send_beat(16'h0000, 16'h7FFF);
        send_beat(16'h8000, 16'h8000);
        send_beat(16'h7FFF, 16'h8000);
        send_beat(16'h0001, 16'h7FFF);
        drain();
        // One four-element row: large gains over mixed elements, epsilon at its largest
        write_reg(CFG_ROW_LENGTH, 16'd4);
        write_reg(CFG_EPSILON, 16'hFFFF);
        send_beat(16'h0100, 16'h7FFF);
        send_beat(16'hFF00, 16'h7FFF);
        send_beat(16'h0001, 16'h8000);
        send_beat(16'h8000, 16'h1000);
        drain();
        // Row length zero
        write_reg(CFG_ROW_LENGTH, 16'd0);
        send_beat(16'h1234, 16'hF000);
        drain();
        // Length lowered in mid-row: the next beat still loads and ends the row
        write_reg(CFG_ROW_LENGTH, 16'd6);
        for (int i = 0; i < 4; i++) send_beat(pick_value(), pick_value());
        drain();
        write_reg(CFG_ROW_LENGTH, 16'd2);
        send_beat(pick_value(), pick_value());
        drain();

        // Random rows across several settings, mostly short
        sent = 0;
        for (int ph = 0; sent < 270; ph++) begin
            rl = (ph < 6) ? lens[ph] : $urandom_range(1, 12);
            write_reg(CFG_ROW_LENGTH, 16'(rl));
            write_reg(CFG_EPSILON,
                      (ph % 3 == 0) ? 16'(eps_vals[(ph / 3) % 4]) : 16'($urandom));
            len = rl == 0 ? 1 : (rl > 64 ? 64 : rl);
            for (int r = 0; r < 3 && sent < 270; r++) begin
                for (int i = 0; i < len; i++) begin
                    send_beat(pick_value(), pick_value(), ($urandom_range(0, 3) == 0));
                    sent++;
                end
            end
            // finish any partial row before the next setting
            while (sb.elem_cnt != 0) begin
                send_beat(pick_value(), pick_value());
                sent++;
            end
            drain();
        end

        drain();
        if (sb.mismatches == 0 && sb.norm_queue.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
